// File: rtl/dph_pkg.sv
// Shared constants, types and state encodings of the decimal digit hash matcher.
package dph_pkg;

  localparam int SEED_W   = 63;
  localparam int MOD_W    = 31;
  localparam int DIG_N    = 19;
  localparam int BCD_W    = DIG_N * 4;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 63;
  localparam int IN_TW    = 64;
  localparam int OUT_TW   = 64;
  localparam int CONV_CW  = 6;
  localparam int STEP_CW  = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_PRIME_ONE   = 3'd0,
    REG_MODULUS_ONE = 3'd1,
    REG_PRIME_TWO   = 3'd2,
    REG_MODULUS_TWO = 3'd3,
    REG_TARGET_ONE  = 3'd4,
    REG_TARGET_TWO  = 3'd5,
    REG_RANGE_LOW   = 3'd6,
    REG_RANGE_HIGH  = 3'd7
  } reg_idx_t;

  // One classified request: decimal digits of the seed and its range flag.
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             in_range;
  } job_t;

  // Status of one hash lane toward the back-end controller.
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] hash;
  } lane_stat_t;

  typedef enum logic [1:0] {FE_IDLE, FE_CONV, FE_PUSH} fe_state_t;
  typedef enum logic [2:0] {LN_IDLE, LN_PRE, LN_MUL, LN_ACC, LN_DONE} ln_state_t;
  typedef enum logic {BK_IDLE, BK_RUN} bk_state_t;

endpackage

// File: rtl/dph_front.sv
// Front end: accepts seeds, converts them to decimal digits and checks the range.
module dph_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dph_pkg::SEED_W-1:0]    seed,
  input  logic [dph_pkg::SEED_W-1:0]    range_low,
  input  logic [dph_pkg::SEED_W-1:0]    range_high,
  output logic                          q_valid,
  input  logic                          q_ready,
  output dph_pkg::job_t                 q_job
);

  dph_pkg::fe_state_t               state_r, state_nxt;
  logic [dph_pkg::SEED_W-1:0]       sh_r, sh_nxt;
  logic [dph_pkg::BCD_W-1:0]        bcd_r, bcd_nxt, bcd_adj;
  logic [dph_pkg::CONV_CW-1:0]      cnt_r, cnt_nxt;
  logic                             inr_r, inr_nxt;

  // Double-dabble correction: every digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < dph_pkg::DIG_N; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Next state: one seed bit shifts into the digit register per cycle.
  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    inr_nxt   = inr_r;
    in_ready  = 1'b0;
    q_valid   = 1'b0;
    case (state_r)
      dph_pkg::FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sh_nxt    = seed;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          inr_nxt   = (seed >= range_low) && (seed < range_high);
          state_nxt = dph_pkg::FE_CONV;
        end
      end
      dph_pkg::FE_CONV: begin
        bcd_nxt = {bcd_adj[dph_pkg::BCD_W-2:0], sh_r[dph_pkg::SEED_W-1]};
        sh_nxt  = {sh_r[dph_pkg::SEED_W-2:0], 1'b0};
        cnt_nxt = cnt_r + dph_pkg::CONV_CW'(1);
        if (cnt_r == dph_pkg::CONV_CW'(dph_pkg::SEED_W - 1)) begin
          state_nxt = dph_pkg::FE_PUSH;
        end
      end
      dph_pkg::FE_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_nxt = dph_pkg::FE_IDLE;
        end
      end
      default: state_nxt = dph_pkg::FE_IDLE;
    endcase
  end

  assign q_job.bcd      = bcd_r;
  assign q_job.in_range = inr_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dph_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    inr_r <= inr_nxt;
  end

endmodule

// File: rtl/dph_fifo.sv
// Two-entry queue that decouples the front end from the hash engine.
module dph_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dph_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dph_pkg::job_t rd_job
);

  dph_pkg::job_t ent_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_job;
    end
  end

endmodule

// File: rtl/dph_lane.sv
// One hash lane: polynomial hash of a digit string with shift-add modular multiplies.
module dph_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dph_pkg::BCD_W-1:0]   bcd,
  input  logic [dph_pkg::MOD_W-1:0]   prime,
  input  logic [dph_pkg::MOD_W-1:0]   modulus,
  output dph_pkg::lane_stat_t         stat
);

  localparam int W = dph_pkg::MOD_W;

  dph_pkg::ln_state_t          state_r, state_nxt;
  logic [dph_pkg::BCD_W-1:0]   bcd_r, bcd_nxt, bcd_sh;
  logic [dph_pkg::STEP_CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] pr_r, pr_nxt, pw_r, pw_nxt, acc_r, acc_nxt;
  logic [W-1:0] rp_r, rp_nxt, rt_r, rt_nxt;
  logic [W-1:0] xp_r, xp_nxt, xt_r, xt_nxt;
  logic [W-1:0] rp_step, rt_step;
  logic [W:0]   acc_sum;
  logic         nz_r, nz_nxt, last_step;

  // Modular double-and-add: (2r + b*y) mod m, with r and y below m.
  function automatic logic [W-1:0] mstep(input logic [W-1:0] r, input logic [W-1:0] y,
                                         input logic [W-1:0] m, input logic b);
    logic [W:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    if (b) t = t + {1'b0, y};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[W-1:0];
  endfunction

  // Digit plus one, as the multiplier of the current term.
  function automatic logic [W-1:0] dig1(input logic [3:0] d);
    return W'({1'b0, d} + 5'd1);
  endfunction

  assign last_step = (cnt_r == dph_pkg::STEP_CW'(W - 1));
  assign bcd_sh    = {4'd0, bcd_r[dph_pkg::BCD_W-1:4]};
  assign acc_sum   = {1'b0, acc_r} + {1'b0, rt_r};

  // The prime pass reuses rp; the multiply pass runs both products side by side.
  always_comb begin
    if (state_r == dph_pkg::LN_PRE) begin
      rp_step = mstep(rp_r, W'(1), modulus, xp_r[W-1]);
    end else begin
      rp_step = mstep(rp_r, pr_r, modulus, xp_r[W-1]);
    end
    rt_step = mstep(rt_r, pw_r, modulus, xt_r[W-1]);
  end

  // Sequencer: reduce the prime once, then one multiply pass and one add per digit.
  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    pr_nxt    = pr_r;
    pw_nxt    = pw_r;
    acc_nxt   = acc_r;
    rp_nxt    = rp_r;
    rt_nxt    = rt_r;
    xp_nxt    = xp_r;
    xt_nxt    = xt_r;
    nz_nxt    = nz_r;
    case (state_r)
      dph_pkg::LN_IDLE, dph_pkg::LN_DONE: begin
        if (start) begin
          bcd_nxt = bcd;
          acc_nxt = W'(1);
          nz_nxt  = (bcd != '0);
          rp_nxt  = '0;
          xp_nxt  = prime;
          cnt_nxt = '0;
          state_nxt = (bcd != '0) ? dph_pkg::LN_PRE : dph_pkg::LN_DONE;
        end
      end
      dph_pkg::LN_PRE: begin
        rp_nxt  = rp_step;
        xp_nxt  = {xp_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + dph_pkg::STEP_CW'(1);
        if (last_step) begin
          pr_nxt  = rp_step;
          pw_nxt  = rp_step;
          xp_nxt  = rp_step;
          xt_nxt  = dig1(bcd_r[3:0]);
          rp_nxt  = '0;
          rt_nxt  = '0;
          cnt_nxt = '0;
          state_nxt = dph_pkg::LN_MUL;
        end
      end
      dph_pkg::LN_MUL: begin
        rp_nxt  = rp_step;
        rt_nxt  = rt_step;
        xp_nxt  = {xp_r[W-2:0], 1'b0};
        xt_nxt  = {xt_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + dph_pkg::STEP_CW'(1);
        if (last_step) begin
          state_nxt = dph_pkg::LN_ACC;
        end
      end
      dph_pkg::LN_ACC: begin
        if (acc_sum >= {1'b0, modulus}) begin
          acc_nxt = acc_sum[W-1:0] - modulus;
        end else begin
          acc_nxt = acc_sum[W-1:0];
        end
        pw_nxt  = rp_r;
        bcd_nxt = bcd_sh;
        xp_nxt  = rp_r;
        xt_nxt  = dig1(bcd_sh[3:0]);
        rp_nxt  = '0;
        rt_nxt  = '0;
        cnt_nxt = '0;
        state_nxt = (bcd_sh == '0) ? dph_pkg::LN_DONE : dph_pkg::LN_MUL;
      end
      default: state_nxt = dph_pkg::LN_IDLE;
    endcase
  end

  // A modulus below two reduces every nonzero seed's hash to zero.
  assign stat.done = (state_r == dph_pkg::LN_DONE);
  assign stat.hash = (nz_r && (modulus < W'(2))) ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dph_pkg::LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    pr_r  <= pr_nxt;
    pw_r  <= pw_nxt;
    acc_r <= acc_nxt;
    rp_r  <= rp_nxt;
    rt_r  <= rt_nxt;
    xp_r  <= xp_nxt;
    xt_r  <= xt_nxt;
    nz_r  <= nz_nxt;
  end

endmodule

// File: rtl/dph_back.sv
// Back end: runs both hash lanes on a queued request and holds the result register.
module dph_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  dph_pkg::job_t                 q_job,
  input  logic [dph_pkg::MOD_W-1:0]     prime_one,
  input  logic [dph_pkg::MOD_W-1:0]     modulus_one,
  input  logic [dph_pkg::MOD_W-1:0]     prime_two,
  input  logic [dph_pkg::MOD_W-1:0]     modulus_two,
  input  logic [dph_pkg::MOD_W-1:0]     target_one,
  input  logic [dph_pkg::MOD_W-1:0]     target_two,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dph_pkg::MOD_W-1:0]     hash_one,
  output logic [dph_pkg::MOD_W-1:0]     hash_two,
  output logic                          is_match
);

  dph_pkg::bk_state_t         state_r, state_nxt;
  dph_pkg::lane_stat_t        st_one, st_two;
  logic                       inr_r, inr_nxt;
  logic                       ov_r, ov_nxt, load, start;
  logic [dph_pkg::MOD_W-1:0]  h1_r, h2_r;
  logic                       m_r;

  dph_lane u_lane_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .bcd     (q_job.bcd),
    .prime   (prime_one),
    .modulus (modulus_one),
    .stat    (st_one)
  );

  dph_lane u_lane_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .bcd     (q_job.bcd),
    .prime   (prime_two),
    .modulus (modulus_two),
    .stat    (st_two)
  );

  // Controller: pop a request, start both lanes, move the result out when there is room.
  always_comb begin
    state_nxt = state_r;
    inr_nxt   = inr_r;
    q_ready   = 1'b0;
    start     = 1'b0;
    load      = 1'b0;
    case (state_r)
      dph_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          start     = 1'b1;
          inr_nxt   = q_job.in_range;
          state_nxt = dph_pkg::BK_RUN;
        end
      end
      dph_pkg::BK_RUN: begin
        if (st_one.done && st_two.done && (!ov_r || out_ready)) begin
          load      = 1'b1;
          state_nxt = dph_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dph_pkg::BK_IDLE;
    endcase
    ov_nxt = load || (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dph_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    inr_r <= inr_nxt;
    if (load) begin
      h1_r <= st_one.hash;
      h2_r <= st_two.hash;
      m_r  <= inr_r && (st_one.hash == target_one) && (st_two.hash == target_two);
    end
  end

  assign out_valid = ov_r;
  assign hash_one  = h1_r;
  assign hash_two  = h2_r;
  assign is_match  = m_r;

endmodule

// File: rtl/decimal_digit_poly_hash_match.sv
// Top level of the decimal digit polynomial hash matcher with its configuration registers.
//
// Each request carries a seed; the block returns two polynomial hashes over the seed's
// decimal digits (least significant first) and a flag that is set when the seed lies in
// [range_low, range_high) and both hashes equal their targets. The front end converts the
// seed to decimal one bit per cycle, and takes a new request only after the previous one has
// entered the two-entry queue, while the back end works on an earlier request from that queue.
// The back end's two lanes each reduce the prime once, then run one shift-add modular
// multiply and one add per decimal digit (at most 19 digits); a zero seed skips both.
// The result register frees the back end as soon as a result is stored.
module decimal_digit_poly_hash_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dph_pkg::IN_TW-1:0]     in_tdata,   // [62:0] seed
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dph_pkg::OUT_TW-1:0]    out_tdata,  // [30:0] hash_one, [61:31] hash_two,
                                                    // [62] is_match
  input  logic                          cfg_we,
  input  logic [dph_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [dph_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int W = dph_pkg::MOD_W;
  localparam int S = dph_pkg::SEED_W;

  logic [W-1:0] prime_one_r, modulus_one_r, prime_two_r, modulus_two_r;
  logic [W-1:0] target_one_r, target_two_r;
  logic [S-1:0] range_low_r, range_high_r;

  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  dph_pkg::job_t fq_job, bq_job;
  logic [W-1:0]  hash_one, hash_two;
  logic          is_match;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_one_r   <= W'(31);
      modulus_one_r <= W'(1000000007);
      prime_two_r   <= W'(37);
      modulus_two_r <= W'(998244353);
      target_one_r  <= '0;
      target_two_r  <= '0;
      range_low_r   <= '0;
      range_high_r  <= '0;
    end else if (cfg_we) begin
      case (dph_pkg::reg_idx_t'(cfg_addr))
        dph_pkg::REG_PRIME_ONE:   prime_one_r   <= cfg_wdata[W-1:0];
        dph_pkg::REG_MODULUS_ONE: modulus_one_r <= cfg_wdata[W-1:0];
        dph_pkg::REG_PRIME_TWO:   prime_two_r   <= cfg_wdata[W-1:0];
        dph_pkg::REG_MODULUS_TWO: modulus_two_r <= cfg_wdata[W-1:0];
        dph_pkg::REG_TARGET_ONE:  target_one_r  <= cfg_wdata[W-1:0];
        dph_pkg::REG_TARGET_TWO:  target_two_r  <= cfg_wdata[W-1:0];
        dph_pkg::REG_RANGE_LOW:   range_low_r   <= cfg_wdata[S-1:0];
        dph_pkg::REG_RANGE_HIGH:  range_high_r  <= cfg_wdata[S-1:0];
        default: ;
      endcase
    end
  end

  dph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .seed       (in_tdata[S-1:0]),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_job      (fq_job)
  );

  dph_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_job   (fq_job),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_job   (bq_job)
  );

  dph_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (bq_valid),
    .q_ready     (bq_ready),
    .q_job       (bq_job),
    .prime_one   (prime_one_r),
    .modulus_one (modulus_one_r),
    .prime_two   (prime_two_r),
    .modulus_two (modulus_two_r),
    .target_one  (target_one_r),
    .target_two  (target_two_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .hash_one    (hash_one),
    .hash_two    (hash_two),
    .is_match    (is_match)
  );

  assign out_tdata = {1'b0, is_match, hash_two, hash_one};

endmodule

// File: verif/decimal_digit_poly_hash_match_tb.sv
// Self-checking testbench for the decimal digit polynomial hash matcher.
module decimal_digit_poly_hash_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected fields of one hash result.
  typedef struct {
    bit [dph_pkg::MOD_W-1:0] hash_one;
    bit [dph_pkg::MOD_W-1:0] hash_two;
    bit                      is_match;
  } hash_result_t;

  // Holds the register copy and the hash results still owed by the block.
  class hash_scoreboard;
    bit [62:0]    regs [8];
    hash_result_t owed [$];
    int           errors;
    int           checked;
    int           hits;

    function new();
      regs[dph_pkg::REG_PRIME_ONE]   = 31;
      regs[dph_pkg::REG_MODULUS_ONE] = 1000000007;
      regs[dph_pkg::REG_PRIME_TWO]   = 37;
      regs[dph_pkg::REG_MODULUS_TWO] = 998244353;
      regs[dph_pkg::REG_TARGET_ONE]  = 0;
      regs[dph_pkg::REG_TARGET_TWO]  = 0;
      regs[dph_pkg::REG_RANGE_LOW]   = 0;
      regs[dph_pkg::REG_RANGE_HIGH]  = 0;
    endfunction

    // Apply a register write the way the block stores it.
    function void write_reg(dph_pkg::reg_idx_t idx, bit [62:0] v);
      if (idx <= dph_pkg::REG_TARGET_TWO) regs[idx] = v & 63'h7FFF_FFFF;
      else regs[idx] = v;
    endfunction

    // Polynomial hash over the decimal digits, least significant digit first.
    static function bit [63:0] digit_hash(bit [62:0] seed, bit [63:0] p, bit [63:0] m);
      bit [63:0] acc;
      bit [63:0] pw;
      bit [63:0] s;
      bit [63:0] term;
      acc = 1;
      pw  = p;
      s   = seed;
      for (int n = 0; n < dph_pkg::DIG_N && s != 0; n++) begin
        term = (m < 2) ? 0 : (((s % 10) + 1) * pw) % m;
        s    = s / 10;
        acc  = (m < 2) ? 0 : (acc + term) % m;
        pw   = (m < 2) ? 0 : (pw * p) % m;
      end
      return acc;
    endfunction

    // Work out the result owed for an accepted request.
    function void note_request(bit [62:0] seed);
      hash_result_t r;
      bit [63:0]    h;
      h = digit_hash(seed, regs[dph_pkg::REG_PRIME_ONE], regs[dph_pkg::REG_MODULUS_ONE]);
      r.hash_one = h[30:0];
      h = digit_hash(seed, regs[dph_pkg::REG_PRIME_TWO], regs[dph_pkg::REG_MODULUS_TWO]);
      r.hash_two = h[30:0];
      r.is_match = seed >= regs[dph_pkg::REG_RANGE_LOW] &&
                   seed < regs[dph_pkg::REG_RANGE_HIGH] &&
                   r.hash_one == regs[dph_pkg::REG_TARGET_ONE] &&
                   r.hash_two == regs[dph_pkg::REG_TARGET_TWO];
      owed = {owed, r};
    endfunction

    // Compare an accepted result with the oldest owed one.
    function void check_result(bit [dph_pkg::OUT_TW-1:0] data);
      hash_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (e.is_match) hits++;
      if (data[30:0] != e.hash_one) begin
        $display("%0t: hash_one expected %0d actual %0d", $time, e.hash_one, data[30:0]);
        errors++;
      end
      if (data[61:31] != e.hash_two) begin
        $display("%0t: hash_two expected %0d actual %0d", $time, e.hash_two, data[61:31]);
        errors++;
      end
      if (data[62] != e.is_match) begin
        $display("%0t: is_match expected %0d actual %0d", $time, e.is_match, data[62]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 0;
  logic                         rst_n = 0;
  logic                         in_tvalid = 0;
  logic                         in_tready;
  logic [dph_pkg::IN_TW-1:0]    in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 0;
  logic [dph_pkg::OUT_TW-1:0]   out_tdata;
  logic                         cfg_we = 0;
  logic [dph_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [dph_pkg::CFG_DW-1:0]   cfg_wdata = '0;

  hash_scoreboard sb = new();
  bit             hold_off_req = 0;
  int             sent = 0;

  decimal_digit_poly_hash_match dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),     // [62:0] seed
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata),   // [30:0] hash_one, [61:31] hash_two, [62] is_match
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata[62:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: stall pattern that changes every window, some windows never stall.
  initial begin
    int stall_pct;
    forever begin
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
      repeat (200) begin
        @(negedge clk);
        if (hold_off_req) begin
          out_tready <= 0;
          repeat (3000) @(negedge clk);
          hold_off_req = 0;
        end
        out_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Generous watchdog.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one seed; return at a falling edge after acceptance and any burst gap.
  int burst_left = 0;
  task automatic send_seed(bit [62:0] seed);
    in_tvalid <= 1;
    in_tdata  <= {1'b0, seed};
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  // Write a register while the block is idle.
  task automatic write_reg(dph_pkg::reg_idx_t idx, bit [62:0] v);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  // Random seed, mostly with few digits and now and then a full 63-bit value.
  function automatic bit [62:0] random_seed();
    bit [63:0] raw;
    bit [63:0] lim;
    int        nd;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return raw[62:0];
    nd  = $urandom_range(1, 8);
    lim = 1;
    repeat (nd) lim = lim * 10;
    return raw[62:0] % lim;
  endfunction

  // Hand a window of seeds to the block in order; one matches unless inverted.
  task automatic match_window(bit inverted);
    bit [62:0] base;
    bit [62:0] pick;
    bit [63:0] h1;
    bit [63:0] h2;
    base = random_seed();
    if (base > 63'h7FFF_FFFF_FFFF_FF00) base = 63'h7FFF_FFFF_FFFF_FF00;
    pick = base + $urandom_range(0, 15);
    h1 = hash_scoreboard::digit_hash(pick, sb.regs[dph_pkg::REG_PRIME_ONE],
                                     sb.regs[dph_pkg::REG_MODULUS_ONE]);
    h2 = hash_scoreboard::digit_hash(pick, sb.regs[dph_pkg::REG_PRIME_TWO],
                                     sb.regs[dph_pkg::REG_MODULUS_TWO]);
    write_reg(dph_pkg::REG_TARGET_ONE, h1[62:0]);
    write_reg(dph_pkg::REG_TARGET_TWO, h2[62:0]);
    write_reg(dph_pkg::REG_RANGE_LOW, inverted ? base + 16 : base);
    write_reg(dph_pkg::REG_RANGE_HIGH, inverted ? base : base + 16);
    for (int i = 0; i < 16; i++) send_seed(base + i);
  endtask

  bit [62:0] edge_seeds [] = '{0, 1, 9, 10, 99, 100, 12345, 999999999,
                               63'd1000000000000000000, 63'd999999999999999999,
                               63'h7FFF_FFFF_FFFF_FFFF, 63'h5555_5555_5555_5555,
                               63'h2AAA_AAAA_AAAA_AAAA};

  initial begin
    bit [62:0] v;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Reset settings: extremes of the seed.
    foreach (edge_seeds[i]) send_seed(edge_seeds[i]);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          // Smallest and largest primes and moduli.
          write_reg(dph_pkg::REG_PRIME_ONE, 0);
          write_reg(dph_pkg::REG_MODULUS_ONE, 2);
          write_reg(dph_pkg::REG_PRIME_TWO, 2147483646);
          write_reg(dph_pkg::REG_MODULUS_TWO, 2147483647);
        end
        1: begin
          // Moduli of zero and one reduce the hash of every nonzero seed to zero.
          write_reg(dph_pkg::REG_PRIME_ONE, 2147483647);
          write_reg(dph_pkg::REG_MODULUS_ONE, 0);
          write_reg(dph_pkg::REG_PRIME_TWO, 5);
          write_reg(dph_pkg::REG_MODULUS_TWO, 1);
        end
        2: begin
          // Primes at or above the modulus.
          write_reg(dph_pkg::REG_PRIME_ONE, 100);
          write_reg(dph_pkg::REG_MODULUS_ONE, 7);
          write_reg(dph_pkg::REG_PRIME_TWO, 2147483646);
          write_reg(dph_pkg::REG_MODULUS_TWO, 3);
        end
        default: begin
          write_reg(dph_pkg::REG_PRIME_ONE, {$urandom} & 32'h7FFF_FFFF);
          write_reg(dph_pkg::REG_MODULUS_ONE, $urandom_range(2, 32'h7FFF_FFFF));
          write_reg(dph_pkg::REG_PRIME_TWO,
                    ($urandom_range(0, 1) == 1) ? $urandom_range(0, 50)
                                                : {$urandom} & 32'h7FFF_FFFF);
          write_reg(dph_pkg::REG_MODULUS_TWO,
                    ($urandom_range(0, 2) == 0) ? $urandom_range(2, 20)
                                                : $urandom_range(2, 32'h7FFF_FFFF));
        end
      endcase
      if (ph < 3) begin
        foreach (edge_seeds[i]) send_seed(edge_seeds[i]);
        wait_idle();
      end
      match_window(ph == 5);
      wait_idle();
      if (ph == 4) begin
        // Every seed but the largest eligible.
        write_reg(dph_pkg::REG_RANGE_LOW, 0);
        write_reg(dph_pkg::REG_RANGE_HIGH, 63'h7FFF_FFFF_FFFF_FFFF);
        hold_off_req = 1;
      end
      for (int i = 0; i < 117; i++) begin
        v = random_seed();
        send_seed(v);
      end
      wait_idle();
    end

    $display("Sent %0d seeds, checked %0d results, %0d of them matches,", sent, sb.checked,
             sb.hits);
    $display("over reset, extreme, degenerate-modulus and random hash settings.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
